FILE: hw/rtl/gf256_erasure_code_combiner_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the GF(2^8) erasure code combiner.
// Each macro checks an implication on the rising edge of clk outside reset.
// ----------------------------------------------------------------------------
`ifndef GF256_ERASURE_CODE_COMBINER_MACROS_SVH
`define GF256_ERASURE_CODE_COMBINER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define GEC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gec assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define GEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gec assertion failed");
`else
`define GEC_ASSERT_SAME(lbl, ante, cons)
`define GEC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/gec_pkg.sv
// ----------------------------------------------------------------------------
// gec_pkg
// Shared types, constants and the GF(2^8) multiply for the erasure combiner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gec_pkg;

  localparam int DEF_MAX_SOURCES = 32;
  localparam int DEF_MAX_OUTPUTS = 32;

  // Register indexes (byte address bits [3:2] of the APB port).
  localparam logic [1:0] REG_FIELD_POLY   = 2'd0;
  localparam logic [1:0] REG_SOURCE_COUNT = 2'd1;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;

  localparam logic [8:0] POLY_RESET = 9'h11D;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic       mem_we;    // coefficient load for row `row`
    logic       mem_re;    // fetch coefficient at `src`
    logic [4:0] row;
    logic [7:0] src;
    logic [7:0] wdata;
    logic       acc_en;    // fold the product into the accumulator
    logic       capture;   // move the finished sum into the output chain
    logic       shift;     // advance the output chain by one cell
    logic [7:0] mul_val;
    logic [7:0] poly;
    logic [5:0] num_out;
  } gec_ctl_t;

  // Shift-and-add multiply over GF(2^8); x^8 is implied by the feedback.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] fb);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ sh;
      end
      sh = {sh[6:0], 1'b0} ^ (sh[7] ? fb : 8'h00);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gec_cell.sv
// ----------------------------------------------------------------------------
// gec_cell
// One output row: its coefficient memory, multiply-accumulate, and one stage
// of the output shift chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gec_cell #(
  parameter int MAX_SOURCES = gec_pkg::DEF_MAX_SOURCES,
  parameter int ROW         = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gec_pkg::gec_ctl_t ctl,
  input  wire logic [7:0]        shift_in,
  output logic      [7:0]        out_q
);
  import gec_pkg::*;

  localparam int SW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam logic [5:0] ROW_ID = 6'(ROW);

  logic [7:0] mem [MAX_SOURCES];
  logic [7:0] coef;
  logic [7:0] acc;
  logic [7:0] acc_next;
  logic [7:0] prod;
  logic [SW-1:0] addr;
  logic          active;

  assign addr     = ctl.src[SW-1:0];
  assign active   = ROW_ID < ctl.num_out;
  assign prod     = gf_mul(coef, ctl.mul_val, ctl.poly);
  assign acc_next = acc ^ (active ? prod : 8'h00);

  always_ff @(posedge clk) begin
    if (ctl.mem_we && ({1'b0, ctl.row} == ROW_ID)) begin
      mem[addr] <= ctl.wdata;
    end
    if (ctl.mem_re) begin
      coef <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= ctl.capture ? 8'h00 : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      out_q <= acc_next;
    end else if (ctl.shift) begin
      out_q <= shift_in;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gf256_erasure_code_combiner.sv
// ----------------------------------------------------------------------------
// gf256_erasure_code_combiner
// GF(2^8) combining data path shared by Reed-Solomon erasure encode and decode.
// ----------------------------------------------------------------------------
// Loads and non-final data items are taken one per cycle, back to back.
// A final-source data item gives its results after the coefficient read and
// the multiply-accumulate into the output chain; they leave one per cycle
// while m_tready is high, row 0 first. A further final-source item is held off
// until the previous burst has gone. Reset restores configuration defaults,
// clears accumulators and empties the output chain; coefficients must be loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "gf256_erasure_code_combiner_macros.svh"

module gf256_erasure_code_combiner #(
  parameter int MAX_SOURCES = gec_pkg::DEF_MAX_SOURCES,
  parameter int MAX_OUTPUTS = gec_pkg::DEF_MAX_OUTPUTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // row_index[4:0], source_index[9:5],
                                      // data_value[17:10], zero pad [23:18]
  input  wire logic        s_tuser,   // mode: 0 load coefficient, 1 data byte
  input  wire logic        s_tlast,   // end_of_block
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // out_row[4:0], out_byte[12:5],
                                      // zero pad [15:13]
  output logic             m_tuser,   // block_end
  output logic             m_tlast    // last
);
  import gec_pkg::*;

  localparam logic [5:0] SRC_CAP = 6'((MAX_SOURCES < 32) ? MAX_SOURCES : 32);
  localparam logic [5:0] OUT_CAP = 6'((MAX_OUTPUTS < 32) ? MAX_OUTPUTS : 32);

  // Configuration registers.
  logic [8:0] field_poly;
  logic [5:0] source_count;
  logic [5:0] output_count;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_poly   <= POLY_RESET;
      source_count <= 6'd1;
      output_count <= 6'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FIELD_POLY:   field_poly   <= pwdata[8:0];
        REG_SOURCE_COUNT: source_count <= pwdata[5:0];
        REG_OUTPUT_COUNT: output_count <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FIELD_POLY:   prdata = 32'(field_poly);
      REG_SOURCE_COUNT: prdata = 32'(source_count);
      REG_OUTPUT_COUNT: prdata = 32'(output_count);
      default:          prdata = '0;
    endcase
  end

  // Effective counts: zero acts as one, and both saturate at the cell limits.
  logic [5:0] eff_ns;
  logic [5:0] eff_no;
  logic [5:0] ns_raw;
  logic [5:0] no_raw;

  assign ns_raw = (source_count == 6'd0) ? 6'd1 : source_count;
  assign no_raw = (output_count == 6'd0) ? 6'd1 : output_count;
  assign eff_ns = (ns_raw > SRC_CAP) ? SRC_CAP : ns_raw;
  assign eff_no = (no_raw > OUT_CAP) ? OUT_CAP : no_raw;

  // Input item decode.
  logic [4:0] in_row;
  logic [4:0] in_src;
  logic [7:0] in_val;
  logic       in_data_ok;
  logic       in_emit;
  logic       in_load_ok;
  logic       s_accept;
  logic       m_accept;

  assign in_row = s_tdata[4:0];
  assign in_src = s_tdata[9:5];
  assign in_val = s_tdata[17:10];

  // A data item beyond the active source count is dropped without effect.
  assign in_data_ok = s_tuser && (6'(in_src) < eff_ns);
  assign in_emit    = in_data_ok && (6'(in_src) == (eff_ns - 6'd1));
  // Loads outside the built table are dropped.
  assign in_load_ok = !s_tuser && (9'(in_row) < 9'(MAX_OUTPUTS))
                    && (9'(in_src) < 9'(MAX_SOURCES));

  // Stage 1 holds the data item while its coefficients come out of memory.
  logic       s1_valid;
  logic       s1_emit;
  logic [7:0] s1_val;
  logic       s1_eob;

  // Output chain occupancy: how many results remain to be delivered.
  logic [5:0] out_cnt;
  logic       out_eob;

  // A final-source item may only enter when the chain will be free for it.
  assign s_tready = !in_emit || ((out_cnt == 6'd0) && !s1_emit);
  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
    end else begin
      s1_valid <= s_accept && in_data_ok;
      s1_emit  <= s_accept && in_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_val <= in_val;
      s1_eob <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= '0;
    end else if (s1_emit) begin
      out_cnt <= eff_no;
    end else if (m_accept) begin
      out_cnt <= out_cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      out_eob <= s1_eob;
    end
  end

  // Control broadcast to the cell row.
  gec_ctl_t ctl;

  always_comb begin
    ctl.mem_we  = s_accept && in_load_ok;
    ctl.mem_re  = s_accept;
    ctl.row     = in_row;
    ctl.src     = 8'(in_src);
    ctl.wdata   = in_val;
    ctl.acc_en  = s1_valid;
    ctl.capture = s1_emit;
    ctl.shift   = m_accept;
    ctl.mul_val = s1_val;
    ctl.poly    = field_poly[7:0];
    ctl.num_out = eff_no;
  end

  // One cell per output row. At a burst the finished sums drop into the
  // cells' output registers, and each delivered result pulls every value one
  // cell closer to cell 0, which faces the result port.
  logic [7:0] cell_out [MAX_OUTPUTS];

  for (genvar i = 0; i < MAX_OUTPUTS; i++) begin : g_cell
    logic [7:0] from_next;
    if (i == MAX_OUTPUTS - 1) begin : g_tail
      assign from_next = 8'h00;
    end else begin : g_link
      assign from_next = cell_out[i+1];
    end
    gec_cell #(
      .MAX_SOURCES(MAX_SOURCES),
      .ROW        (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .shift_in(from_next),
      .out_q   (cell_out[i])
    );
  end

  // Row number counts up from zero as the burst drains.
  logic [5:0] row_num;

  assign row_num  = eff_no - out_cnt;
  assign m_tvalid = out_cnt != 6'd0;
  assign m_tdata  = {3'b000, cell_out[0], row_num[4:0]};
  assign m_tlast  = out_cnt == 6'd1;
  assign m_tuser  = out_eob;

  // A burst only lands in an empty output chain.
  `GEC_ASSERT_SAME(a_capture_empty, s1_emit, out_cnt == 6'd0)
  // Every burst leaves at least one result behind it.
  `GEC_ASSERT_NEXT(a_capture_fills, s1_emit, out_cnt != 6'd0)
  // Taking the last result empties the chain; no burst can land that cycle.
  `GEC_ASSERT_NEXT(a_last_drains, m_accept && (out_cnt == 6'd1), out_cnt == 6'd0)

endmodule

`default_nettype wire
